/* rtl/core/rdd_pkg.sv */
package rdd_pkg;

    localparam int SAMPLE_W = 24;
    localparam int TRIG_W   = 17;
    localparam int LON_W    = 21;
    localparam int SQ_W     = 40;
    localparam int ROOT_W   = 20;
    localparam int FRAC_W   = 15;
    localparam int WGT_W    = 16;
    localparam int PROD_W   = 41;
    localparam int ACC_W    = 42;
    localparam int OFF_W    = 29;
    localparam int CFG_IDX_W = 2;

    localparam logic [WGT_W-1:0] ONE_Q15 = 16'd32768;
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXCURSION  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIC_DIST   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE      = 2'd3;

    typedef struct packed {
        logic valid;
        logic mic;
        logic tap0;
        logic last;
    } rd_step_t;

endpackage

/* rtl/core/rdd_store.sv */
module rdd_store #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [AW-1:0]                 wr_addr,
    input  logic [rdd_pkg::SAMPLE_W-1:0]  wr_data,
    input  logic [AW-1:0]                 rd_addr,
    output logic [rdd_pkg::SAMPLE_W-1:0]  rd_data
);

    logic [rdd_pkg::SAMPLE_W-1:0] mem [DEPTH];
    logic [rdd_pkg::SAMPLE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/rdd_lane.sv */
module rdd_lane #(
    parameter int DELAY_DEPTH = 2048,
    parameter int AW          = 11
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic                               add_trig,
    input  logic signed [rdd_pkg::TRIG_W-1:0]  trig_lon,
    input  logic signed [rdd_pkg::TRIG_W-1:0]  trig_trans,
    input  logic [15:0]                        mic_dist,
    input  logic [7:0]                         excursion,
    output logic                               valid,
    output logic [AW-1:0]                      delay_int,
    output logic [rdd_pkg::FRAC_W-1:0]         delay_frac
);

    localparam logic [31:0] LIM = 32'(DELAY_DEPTH - 1) << rdd_pkg::FRAC_W;

    typedef enum logic [5:0] {
        L_IDLE = 6'b000001,
        L_SQ   = 6'b000010,
        L_SUM  = 6'b000100,
        L_ROOT = 6'b001000,
        L_MUL  = 6'b010000,
        L_SAT  = 6'b100000
    } lane_state_t;

    lane_state_t                        state_reg;
    logic signed [rdd_pkg::LON_W-1:0]   lon_reg;
    logic signed [rdd_pkg::TRIG_W-1:0]  trans_reg;
    logic [rdd_pkg::SQ_W-1:0]           lsq_reg;
    logic [rdd_pkg::SQ_W-1:0]           tsq_reg;
    logic [rdd_pkg::SQ_W-1:0]           rem_reg;
    logic [rdd_pkg::SQ_W-1:0]           res_reg;
    logic [rdd_pkg::SQ_W-1:0]           bit_reg;
    logic [4:0]                         cnt_reg;
    logic [rdd_pkg::OFF_W-1:0]          off_reg;
    logic                               valid_reg;
    logic [AW-1:0]                      d_reg;
    logic [rdd_pkg::FRAC_W-1:0]         f_reg;

    logic signed [rdd_pkg::LON_W-1:0]     mic_q15;
    logic signed [rdd_pkg::LON_W-1:0]     lon_next;
    logic signed [2*rdd_pkg::LON_W-1:0]   lon_sq;
    logic signed [2*rdd_pkg::TRIG_W-1:0]  trans_sq;
    logic [rdd_pkg::SQ_W-1:0]             trial;
    logic [rdd_pkg::ROOT_W:0]             scale;
    logic [31:0]                          off_ext;

    always_comb begin
        mic_q15  = $signed({2'b00, mic_dist, 3'b000});
        lon_next = add_trig ? mic_q15 + rdd_pkg::LON_W'(trig_lon)
                            : mic_q15 - rdd_pkg::LON_W'(trig_lon);
        lon_sq   = lon_reg * lon_reg;
        trans_sq = trans_reg * trans_reg;
        trial    = res_reg + bit_reg;
        scale    = (rdd_pkg::ROOT_W + 1)'(rdd_pkg::ONE_Q15)
                 + (rdd_pkg::ROOT_W + 1)'(res_reg[rdd_pkg::ROOT_W-1:0]);
        off_ext  = 32'(off_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            case (state_reg)
                L_IDLE: begin
                    if (start) begin
                        lon_reg   <= lon_next;
                        trans_reg <= trig_trans;
                        valid_reg <= 1'b0;
                        state_reg <= L_SQ;
                    end
                end
                L_SQ: begin
                    lsq_reg   <= lon_sq[rdd_pkg::SQ_W-1:0];
                    tsq_reg   <= rdd_pkg::SQ_W'(unsigned'(trans_sq));
                    state_reg <= L_SUM;
                end
                L_SUM: begin
                    rem_reg   <= lsq_reg + tsq_reg;
                    res_reg   <= '0;
                    bit_reg   <= rdd_pkg::SQ_W'(1) << (rdd_pkg::SQ_W - 2);
                    cnt_reg   <= '0;
                    state_reg <= L_ROOT;
                end
                L_ROOT: begin
                    if (rem_reg >= trial) begin
                        rem_reg <= rem_reg - trial;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end else begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'(rdd_pkg::ROOT_W - 1)) begin
                        state_reg <= L_MUL;
                    end
                end
                L_MUL: begin
                    off_reg   <= rdd_pkg::OFF_W'(excursion) * rdd_pkg::OFF_W'(scale);
                    state_reg <= L_SAT;
                end
                L_SAT: begin
                    if (off_ext > LIM) begin
                        d_reg <= AW'(DELAY_DEPTH - 1);
                        f_reg <= '0;
                    end else begin
                        d_reg <= off_ext[rdd_pkg::FRAC_W +: AW];
                        f_reg <= off_ext[rdd_pkg::FRAC_W-1:0];
                    end
                    valid_reg <= 1'b1;
                    state_reg <= L_IDLE;
                end
                default: begin
                    state_reg <= L_IDLE;
                end
            endcase
        end
    end

    assign valid      = valid_reg;
    assign delay_int  = d_reg;
    assign delay_frac = f_reg;

endmodule

/* rtl/core/rdd_merge.sv */
module rdd_merge (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  rdd_pkg::rd_step_t                  step,
    input  logic [rdd_pkg::SAMPLE_W-1:0]       data_a,
    input  logic [rdd_pkg::SAMPLE_W-1:0]       data_b,
    input  logic [rdd_pkg::WGT_W-1:0]          wgt_a,
    input  logic [rdd_pkg::WGT_W-1:0]          wgt_b,
    output logic                               done,
    output logic [rdd_pkg::SAMPLE_W-1:0]       left_out,
    output logic [rdd_pkg::SAMPLE_W-1:0]       right_out
);

    rdd_pkg::rd_step_t                  ctl_reg;
    logic signed [rdd_pkg::PROD_W-1:0]  prod_a_reg;
    logic signed [rdd_pkg::PROD_W-1:0]  prod_b_reg;
    logic signed [rdd_pkg::ACC_W-1:0]   acc_l_reg;
    logic signed [rdd_pkg::ACC_W-1:0]   acc_r_reg;
    logic                               done_reg;

    logic signed [rdd_pkg::ACC_W-1:0]   pair_sum;
    logic signed [rdd_pkg::ACC_W-1:0]   rnd_l;
    logic signed [rdd_pkg::ACC_W-1:0]   rnd_r;

    always_comb begin
        pair_sum = rdd_pkg::ACC_W'(prod_a_reg) + rdd_pkg::ACC_W'(prod_b_reg);
        rnd_l    = acc_l_reg + rdd_pkg::ACC_W'(rdd_pkg::ONE_Q15);
        rnd_r    = acc_r_reg + rdd_pkg::ACC_W'(rdd_pkg::ONE_Q15);
    end

    always_ff @(posedge aclk) begin
        prod_a_reg <= $signed(data_a) * $signed({1'b0, wgt_a});
        prod_b_reg <= $signed(data_b) * $signed({1'b0, wgt_b});
        if (ctl_reg.valid) begin
            if (ctl_reg.mic) begin
                acc_r_reg <= ctl_reg.tap0 ? pair_sum : acc_r_reg + pair_sum;
            end else begin
                acc_l_reg <= ctl_reg.tap0 ? pair_sum : acc_l_reg + pair_sum;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            ctl_reg  <= step;
            done_reg <= ctl_reg.valid & ctl_reg.last;
        end
    end

    assign done      = done_reg;
    assign left_out  = rnd_l[16 +: rdd_pkg::SAMPLE_W];
    assign right_out = rnd_r[16 +: rdd_pkg::SAMPLE_W];

endmodule

/* rtl/core/rotary_doppler_delay_core.sv */
// Channel   Direction  Handshake                Payload
// s_        in         s_tvalid / s_tready      s_tdata: horn_a_sample, horn_b_sample
// m_        out        m_tvalid / m_tready      m_tdata: left_out, right_out
// cfg_      in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
// A request passes through table lookup, lane start, the four lanes (bit-serial square root),
// a wait to see them finish, four read steps, the merge and the load of the output register.
// No new request is taken until that result is loaded and the core is idle again.
// After reset the delay stores are cleared, every address in turn; no request is taken
// meanwhile, though configuration writes are. A finished result waits in the output
// register while the next sample is accepted; only loading a further result stalls on it.
module rotary_doppler_delay_core #(
    parameter int DELAY_DEPTH      = 2048,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [47:0]                         s_tdata,   // horn_a_sample, horn_b_sample
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [47:0]                         m_tdata,   // left_out, right_out
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rdd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [31:0]                         cfg_data
);

    localparam int AW = $clog2(DELAY_DEPTH);
    localparam int SW = $clog2(SINE_TABLE_DEPTH);
    localparam int TW = rdd_pkg::TRIG_W;

    typedef logic signed [TW-1:0] sine_rom_t [SINE_TABLE_DEPTH];

    function automatic sine_rom_t sine_rom_init();
        sine_rom_t  rom;
        logic [63:0] u;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] acc;
        logic [63:0] t;
        logic        neg;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
            u   = (64'(k) << 32) / SINE_TABLE_DEPTH;
            neg = 1'b0;
            if (u >= 64'h8000_0000) begin
                neg = 1'b1;
                u   = 64'h1_0000_0000 - u;
            end
            if (u > 64'h4000_0000) begin
                u = 64'h8000_0000 - u;
            end
            x    = (u * rdd_pkg::TWO_PI_Q30) >> 32;
            x2   = (x * x) >> 30;
            term = x;
            acc  = x;
            for (int n = 1; n <= 8; n++) begin
                t = (term * x2) >> 30;
                case (n)
                    1:       term = t / 6;
                    2:       term = t / 20;
                    3:       term = t / 42;
                    4:       term = t / 72;
                    5:       term = t / 110;
                    6:       term = t / 156;
                    7:       term = t / 210;
                    default: term = t / 272;
                endcase
                if (n % 2 == 1) begin
                    acc = acc - term;
                end else begin
                    acc = acc + term;
                end
            end
            acc    = (acc + 64'd16384) >> 15;
            rom[k] = neg ? -$signed(TW'(acc)) : $signed(TW'(acc));
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = sine_rom_init();

    typedef enum logic [7:0] {
        S_CLEAR = 8'b00000001,
        S_IDLE  = 8'b00000010,
        S_TRIG  = 8'b00000100,
        S_LANE  = 8'b00001000,
        S_WAIT  = 8'b00010000,
        S_READ  = 8'b00100000,
        S_DRAIN = 8'b01000000,
        S_OUT   = 8'b10000000
    } core_state_t;

    core_state_t        state_reg;
    logic [AW-1:0]      clr_cnt_reg;
    logic [AW-1:0]      wp_reg;
    logic [AW-1:0]      base_reg;
    logic [31:0]        phase_reg;
    logic [31:0]        phase_step_reg;
    logic [7:0]         excursion_reg;
    logic [15:0]        mic_dist_reg;
    logic [SW-1:0]      idx_reg;
    logic [SW-1:0]      cidx_reg;
    logic signed [TW-1:0] sin_reg;
    logic signed [TW-1:0] cos_reg;
    logic [1:0]         rd_cnt_reg;
    logic               m_tvalid_reg;
    logic [47:0]        m_tdata_reg;
    rdd_pkg::rd_step_t  issue_reg;
    rdd_pkg::rd_step_t  issue_next;
    logic [rdd_pkg::WGT_W-1:0] wgt_a_reg;
    logic [rdd_pkg::WGT_W-1:0] wgt_b_reg;

    logic               accept;
    logic               lane_start;
    logic [3:0]         lane_valid;
    logic [AW-1:0]      lane_d [4];
    logic [rdd_pkg::FRAC_W-1:0] lane_f [4];
    logic               out_free;
    logic [63:0]        idx_prod;
    logic [SW:0]        cidx_sum;
    logic               st_wr_en;
    logic [AW-1:0]      st_wr_addr;
    logic [rdd_pkg::SAMPLE_W-1:0] st_wr_a;
    logic [rdd_pkg::SAMPLE_W-1:0] st_wr_b;
    logic [AW-1:0]      rd_addr_a;
    logic [AW-1:0]      rd_addr_b;
    logic [rdd_pkg::SAMPLE_W-1:0] rd_data_a;
    logic [rdd_pkg::SAMPLE_W-1:0] rd_data_b;
    logic [rdd_pkg::WGT_W-1:0] wgt_a_next;
    logic [rdd_pkg::WGT_W-1:0] wgt_b_next;
    logic               merge_done;
    logic [rdd_pkg::SAMPLE_W-1:0] mix_left;
    logic [rdd_pkg::SAMPLE_W-1:0] mix_right;
    logic               rd_mic;
    logic               rd_tap1;

    function automatic logic [AW-1:0] tap_addr(input logic [AW-1:0] base,
                                               input logic [AW-1:0] d,
                                               input logic tap1);
        logic [AW:0]   diff;
        logic [AW-1:0] i0;
        diff = {1'b0, base} - {1'b0, d};
        if (diff[AW]) begin
            diff = diff + (AW + 1)'(DELAY_DEPTH);
        end
        i0 = diff[AW-1:0];
        if (!tap1) begin
            return i0;
        end
        return (i0 == '0) ? AW'(DELAY_DEPTH - 1) : i0 - AW'(1);
    endfunction

    function automatic logic [rdd_pkg::WGT_W-1:0] tap_wgt(
            input logic [rdd_pkg::FRAC_W-1:0] f, input logic tap1);
        return tap1 ? rdd_pkg::WGT_W'(f) : rdd_pkg::ONE_Q15 - rdd_pkg::WGT_W'(f);
    endfunction

    assign accept    = s_tvalid & s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign lane_start = (state_reg == S_LANE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_comb begin
        idx_prod   = 64'(phase_reg) * 64'(SINE_TABLE_DEPTH);
        cidx_sum   = (SW + 1)'(idx_prod[32 +: SW]) + (SW + 1)'(SINE_TABLE_DEPTH / 4);
        if (cidx_sum >= (SW + 1)'(SINE_TABLE_DEPTH)) begin
            cidx_sum = cidx_sum - (SW + 1)'(SINE_TABLE_DEPTH);
        end
        st_wr_en   = (state_reg == S_CLEAR) || accept;
        st_wr_addr = (state_reg == S_CLEAR) ? clr_cnt_reg : wp_reg;
        st_wr_a    = (state_reg == S_CLEAR) ? '0 : s_tdata[23:0];
        st_wr_b    = (state_reg == S_CLEAR) ? '0 : s_tdata[47:24];
        rd_mic     = rd_cnt_reg[1];
        rd_tap1    = rd_cnt_reg[0];
        rd_addr_a  = tap_addr(base_reg, rd_mic ? lane_d[2] : lane_d[0], rd_tap1);
        rd_addr_b  = tap_addr(base_reg, rd_mic ? lane_d[3] : lane_d[1], rd_tap1);
        wgt_a_next = tap_wgt(rd_mic ? lane_f[2] : lane_f[0], rd_tap1);
        wgt_b_next = tap_wgt(rd_mic ? lane_f[3] : lane_f[1], rd_tap1);
        issue_next.valid = (state_reg == S_READ);
        issue_next.mic   = rd_mic;
        issue_next.tap0  = !rd_tap1;
        issue_next.last  = (rd_cnt_reg == 2'd3);
    end

    rdd_store #(.DEPTH(DELAY_DEPTH), .AW(AW)) u_store_a (
        .aclk    (aclk),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (st_wr_a),
        .rd_addr (rd_addr_a),
        .rd_data (rd_data_a)
    );

    rdd_store #(.DEPTH(DELAY_DEPTH), .AW(AW)) u_store_b (
        .aclk    (aclk),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (st_wr_b),
        .rd_addr (rd_addr_b),
        .rd_data (rd_data_b)
    );

    // Lanes: horn A left, horn B left, horn A right, horn B right.
    rdd_lane #(.DELAY_DEPTH(DELAY_DEPTH), .AW(AW)) u_lane_al (
        .aclk (aclk), .aresetn (aresetn), .start (lane_start), .add_trig (1'b0),
        .trig_lon (sin_reg), .trig_trans (cos_reg),
        .mic_dist (mic_dist_reg), .excursion (excursion_reg),
        .valid (lane_valid[0]), .delay_int (lane_d[0]), .delay_frac (lane_f[0])
    );

    rdd_lane #(.DELAY_DEPTH(DELAY_DEPTH), .AW(AW)) u_lane_bl (
        .aclk (aclk), .aresetn (aresetn), .start (lane_start), .add_trig (1'b1),
        .trig_lon (sin_reg), .trig_trans (cos_reg),
        .mic_dist (mic_dist_reg), .excursion (excursion_reg),
        .valid (lane_valid[1]), .delay_int (lane_d[1]), .delay_frac (lane_f[1])
    );

    rdd_lane #(.DELAY_DEPTH(DELAY_DEPTH), .AW(AW)) u_lane_ar (
        .aclk (aclk), .aresetn (aresetn), .start (lane_start), .add_trig (1'b0),
        .trig_lon (cos_reg), .trig_trans (sin_reg),
        .mic_dist (mic_dist_reg), .excursion (excursion_reg),
        .valid (lane_valid[2]), .delay_int (lane_d[2]), .delay_frac (lane_f[2])
    );

    rdd_lane #(.DELAY_DEPTH(DELAY_DEPTH), .AW(AW)) u_lane_br (
        .aclk (aclk), .aresetn (aresetn), .start (lane_start), .add_trig (1'b1),
        .trig_lon (cos_reg), .trig_trans (sin_reg),
        .mic_dist (mic_dist_reg), .excursion (excursion_reg),
        .valid (lane_valid[3]), .delay_int (lane_d[3]), .delay_frac (lane_f[3])
    );

    rdd_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (issue_reg),
        .data_a    (rd_data_a),
        .data_b    (rd_data_b),
        .wgt_a     (wgt_a_reg),
        .wgt_b     (wgt_b_reg),
        .done      (merge_done),
        .left_out  (mix_left),
        .right_out (mix_right)
    );

    always_ff @(posedge aclk) begin
        wgt_a_reg <= wgt_a_next;
        wgt_b_reg <= wgt_b_next;
        if (state_reg == S_TRIG) begin
            sin_reg <= SINE_ROM[idx_reg];
            cos_reg <= SINE_ROM[cidx_reg];
        end
        if (accept) begin
            idx_reg  <= idx_prod[32 +: SW];
            cidx_reg <= cidx_sum[SW-1:0];
            base_reg <= wp_reg;
        end
        if (state_reg == S_OUT && out_free) begin
            m_tdata_reg <= {mix_right, mix_left};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            wp_reg         <= '0;
            phase_reg      <= '0;
            phase_step_reg <= '0;
            excursion_reg  <= 8'd8;
            mic_dist_reg   <= 16'd4096;
            rd_cnt_reg     <= '0;
            m_tvalid_reg   <= 1'b0;
            issue_reg      <= '0;
        end else begin
            issue_reg <= issue_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    rdd_pkg::CFG_PHASE_STEP: phase_step_reg <= cfg_data;
                    rdd_pkg::CFG_EXCURSION:  excursion_reg  <= cfg_data[7:0];
                    rdd_pkg::CFG_MIC_DIST:   mic_dist_reg   <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (m_tvalid_reg && m_tready && state_reg != S_OUT) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + AW'(1);
                    if (clr_cnt_reg == AW'(DELAY_DEPTH - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        wp_reg    <= (wp_reg == AW'(DELAY_DEPTH - 1)) ? '0 : wp_reg + AW'(1);
                        phase_reg <= phase_reg + phase_step_reg;
                        state_reg <= S_TRIG;
                    end
                end
                S_TRIG: begin
                    state_reg <= S_LANE;
                end
                S_LANE: begin
                    state_reg <= S_WAIT;
                end
                S_WAIT: begin
                    if (&lane_valid) begin
                        rd_cnt_reg <= '0;
                        state_reg  <= S_READ;
                    end
                end
                S_READ: begin
                    rd_cnt_reg <= rd_cnt_reg + 2'd1;
                    if (rd_cnt_reg == 2'd3) begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (merge_done) begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_lanes_together: assert property (@(posedge aclk) disable iff (!aresetn)
        (lane_valid == 4'b0000) || (lane_valid == 4'b1111))
        else $error("Lanes finished at different times.");

    a_merge_in_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        merge_done |-> (state_reg == S_DRAIN))
        else $error("Merge finished outside the drain phase.");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_OUT))
        else $error("Result presented without passing the output phase.");

    a_no_take_in_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_READ) |-> !s_tready && issue_next.valid)
        else $error("Request taken while the stores are being read.");

endmodule

/* tb/sv/rotary_doppler_delay_checker.sv */
module rotary_doppler_delay_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [rdd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0] cfg_data,
    output int          fail_count,
    output int          pending
);

    localparam int STORE_DEPTH = 2048;
    localparam int TABLE_DEPTH = 1024;

    int                   sine_q15 [TABLE_DEPTH];
    logic signed [23:0]   horn_a_mem [STORE_DEPTH];
    logic signed [23:0]   horn_b_mem [STORE_DEPTH];
    int unsigned          wr_pos;
    logic [31:0]          rot_phase;
    logic [31:0]          step_reg;
    logic [7:0]           exc_reg;
    logic [15:0]          mic_reg;
    logic [47:0]          mic_pair_q [$];

    function automatic int taylor_sine(int k);
        logic [31:0]     u;
        bit              neg;
        longint unsigned x, x2, term, sum;
        u = 32'(k) << 22;
        neg = 1'b0;
        if (u >= 32'h8000_0000) begin
            neg = 1'b1;
            u = 32'(0) - u;
        end
        if (u > 32'h4000_0000) begin
            u = 32'h8000_0000 - u;
        end
        x = (longint'(u) * longint'(rdd_pkg::TWO_PI_Q30)) >> 32;
        x2 = (x * x) >> 30;
        term = x;
        sum = x;
        for (int n = 1; n <= 8; n++) begin
            term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        sum = (sum + (1 << 14)) >> 15;
        return neg ? -int'(sum) : int'(sum);
    endfunction

    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) begin
            bitv = bitv >> 2;
        end
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint unsigned horn_delay(int lon_trig, int trans, int sgn);
        longint          lon;
        longint unsigned sq, off, lim;
        lon = (longint'(mic_reg) << 3) - longint'(sgn) * longint'(lon_trig);
        sq = longint'(lon * lon) + longint'(longint'(trans) * longint'(trans));
        off = longint'(exc_reg) * (longint'(32768) + floor_root(sq));
        lim = longint'(STORE_DEPTH - 1) << 15;
        return off > lim ? lim : off;
    endfunction

    function automatic longint tap_read(bit horn_b, longint unsigned off);
        int unsigned d, f, i0, i1;
        longint      x0, x1;
        d = int'(off >> 15);
        f = int'(off & 64'h7FFF);
        i0 = (wr_pos + STORE_DEPTH - (d % STORE_DEPTH)) % STORE_DEPTH;
        i1 = (i0 + STORE_DEPTH - 1) % STORE_DEPTH;
        x0 = horn_b ? longint'(horn_b_mem[i0]) : longint'(horn_a_mem[i0]);
        x1 = horn_b ? longint'(horn_b_mem[i1]) : longint'(horn_a_mem[i1]);
        return longint'(32768 - f) * x0 + longint'(f) * x1;
    endfunction

    function automatic logic [23:0] mix_round(longint acc);
        longint r;
        r = (acc + 32768) >>> 16;
        return r[23:0];
    endfunction

    initial begin
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            sine_q15[k] = taylor_sine(k);
        end
    end

    assign pending = mic_pair_q.size();

    always @(posedge aclk) begin
        int          idx, s, c;
        longint      left_acc, right_acc;
        logic [47:0] want;
        if (!aresetn) begin
            for (int i = 0; i < STORE_DEPTH; i++) begin
                horn_a_mem[i] = '0;
                horn_b_mem[i] = '0;
            end
            wr_pos = 0;
            rot_phase = '0;
            step_reg = '0;
            exc_reg = 8'd8;
            mic_reg = 16'd4096;
            mic_pair_q.delete();
            fail_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (mic_pair_q.size() == 0) begin
                    $error("unexpected result %h", m_tdata);
                    fail_count++;
                end else begin
                    want = mic_pair_q.pop_front();
                    if (m_tdata[23:0] !== want[23:0]) begin
                        $error("left_out expected %h got %h", want[23:0], m_tdata[23:0]);
                        fail_count++;
                    end
                    if (m_tdata[47:24] !== want[47:24]) begin
                        $error("right_out expected %h got %h", want[47:24], m_tdata[47:24]);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    rdd_pkg::CFG_PHASE_STEP: step_reg = cfg_data;
                    rdd_pkg::CFG_EXCURSION:  exc_reg = cfg_data[7:0];
                    rdd_pkg::CFG_MIC_DIST:   mic_reg = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                horn_a_mem[wr_pos] = s_tdata[23:0];
                horn_b_mem[wr_pos] = s_tdata[47:24];
                idx = int'((longint'(rot_phase) * TABLE_DEPTH) >> 32) % TABLE_DEPTH;
                s = sine_q15[idx];
                c = sine_q15[(idx + TABLE_DEPTH / 4) % TABLE_DEPTH];
                left_acc = tap_read(1'b0, horn_delay(s, c, 1))
                         + tap_read(1'b1, horn_delay(s, c, -1));
                right_acc = tap_read(1'b0, horn_delay(c, s, 1))
                          + tap_read(1'b1, horn_delay(c, s, -1));
                mic_pair_q.push_back({mix_round(right_acc), mix_round(left_acc)});
                wr_pos = (wr_pos + 1) % STORE_DEPTH;
                rot_phase = rot_phase + step_reg;
            end
        end
    end

endmodule

/* tb/sv/rotary_doppler_delay_core_tb.sv */
module rotary_doppler_delay_core_tb;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;    // horn_a_sample, horn_b_sample
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;    // left_out, right_out
    logic        cfg_valid;
    logic        cfg_ready;
    logic [rdd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [31:0] cfg_data;
    int          fail_count;
    int          pending;
    bit          hold_req;

    rotary_doppler_delay_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    rotary_doppler_delay_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int gap_length();
        if ($urandom_range(0, 19) == 0) begin
            return $urandom_range(20, 60);
        end
        return $urandom_range(0, 3);
    endfunction

    initial begin
        bit held;
        held = 1'b0;
        m_tready = 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_req && !held) begin
                held = 1'b1;
                m_tready <= 1'b0;
                for (int n = 0; n < 400; n++) begin
                    @(posedge aclk);
                end
            end else if ($urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat (gap_length() + 1) @(posedge aclk);
                m_tready <= 1'b1;
                @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge aclk);
            end
        end
    end

    task automatic write_reg(logic [rdd_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(negedge aclk); while (!cfg_ready);
        @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_rotor(logic [31:0] step, logic [7:0] exc, logic [15:0] radius);
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        write_reg(rdd_pkg::CFG_PHASE_STEP, step);
        write_reg(rdd_pkg::CFG_EXCURSION, {24'(0), exc});
        write_reg(rdd_pkg::CFG_MIC_DIST, {16'(0), radius});
    endtask

    task automatic send_pair(logic [23:0] horn_a, logic [23:0] horn_b, bit idle_ok);
        int gap;
        gap = idle_ok ? gap_length() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {horn_b, horn_a};
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
    endtask

    task automatic send_random(int count);
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 5))
                0: send_pair(24'h7FFFFF, 24'h800000, 1'b1);
                1: send_pair(24'(-$urandom_range(0, 4)), 24'($urandom_range(0, 4)), 1'b1);
                default: send_pair(24'($urandom), 24'($urandom), 1'b1);
            endcase
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        hold_req = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings first, with the full-scale and near-zero samples.
        send_pair(24'h7FFFFF, 24'h800000, 1'b0);
        send_pair(24'h800000, 24'h7FFFFF, 1'b0);
        send_pair(24'h000000, 24'hFFFFFF, 1'b1);
        send_pair(24'h000001, 24'h000000, 1'b1);
        send_pair(24'h555555, 24'hAAAAAA, 1'b1);
        s_tvalid <= 1'b0;

        // Zero excursion gives zero delay, so each output is the average of the current horn samples.
        set_rotor(32'h0100_0000, 8'd0, 16'd0);
        write_reg(rdd_pkg::CFG_SPARE, 32'hFFFF_FFFF);
        send_pair(24'h7FFFFF, 24'h7FFFFF, 1'b0);
        send_pair(24'h800000, 24'h800000, 1'b0);
        send_pair(24'h123456, 24'hEDCBA9, 1'b1);
        s_tvalid <= 1'b0;

        // Largest excursion and distance drive the delay into saturation.
        set_rotor(32'hFFFF_FFFF, 8'd255, 16'hFFFF);
        for (int n = 0; n < 6; n++) begin
            send_pair(24'h7FFFFF, 24'h800000, 1'b0);
        end
        s_tvalid <= 1'b0;

        set_rotor(32'h0123_4567, 8'd8, 16'd4096);
        send_random(300);
        hold_req = 1'b1;
        send_random(200);

        for (int p = 0; p < 5; p++) begin
            set_rotor(32'($urandom), 8'($urandom_range(0, 20)), 16'($urandom));
            send_random(200);
        end
        set_rotor(32'($urandom), 8'($urandom), 16'($urandom_range(0, 8192)));
        send_random(50);

        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #50000000;
        $display("Verification failed");
        $finish;
    end

endmodule
